>>> src/scga_pkg.sv
// Shared constants, codes and the configuration register type for the calibration averager.
`timescale 1ns / 1ps
package scga_pkg;

	// default build parameters
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int SUM_WIDTH_DEF    = 32;
	localparam int TIMER_WIDTH_DEF  = 16;

	// stream and register port widths
	localparam int IN_W    = 40;
	localparam int OUT_W   = 80;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int FIELD_W = 16;

	// fixed counter widths
	localparam int CNT_W = 16;
	localparam int ST_W  = 10;
	localparam int THR_W = 17;

	// register indexes
	localparam logic [2:0] REG_MOVE_THR    = 3'd0;
	localparam logic [2:0] REG_MIN_SAMPLES = 3'd1;
	localparam logic [2:0] REG_READY_MS    = 3'd2;
	localparam logic [2:0] REG_HOLD_MS     = 3'd3;
	localparam logic [2:0] REG_TIMEOUT_MS  = 3'd4;
	localparam logic [2:0] REG_SAMPLE_PER  = 3'd5;
	localparam logic [2:0] REG_BEEP_PER    = 3'd6;
	localparam logic [2:0] REG_RESULT_HOLD = 3'd7;

	// register reset values
	localparam logic [THR_W-1:0] RST_MOVE_THR    = 17'd1000;
	localparam logic [15:0]      RST_MIN_SAMPLES = 16'd50;
	localparam logic [15:0]      RST_READY_MS    = 16'd3000;
	localparam logic [15:0]      RST_HOLD_MS     = 16'd5000;
	localparam logic [15:0]      RST_TIMEOUT_MS  = 16'd10000;
	localparam logic [ST_W-1:0]  RST_SAMPLE_PER  = 10'd50;
	localparam logic [15:0]      RST_BEEP_PER    = 16'd1000;
	localparam logic [15:0]      RST_RESULT_HOLD = 16'd4000;

	// event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_START    = 3'd1;
	localparam logic [2:0] EV_CANCEL   = 3'd2;
	localparam logic [2:0] EV_MOVED    = 3'd3;
	localparam logic [2:0] EV_TIMEOUT  = 3'd4;
	localparam logic [2:0] EV_COMPLETE = 3'd5;

	// visible result codes
	localparam logic [1:0] RES_NONE     = 2'd0;
	localparam logic [1:0] RES_COMPLETE = 2'd1;
	localparam logic [1:0] RES_FAILED   = 2'd2;

	// phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_READY = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;

	typedef struct packed {
		logic [THR_W-1:0] move_threshold;
		logic [15:0]      min_samples;
		logic [15:0]      ready_ms;
		logic [15:0]      hold_ms;
		logic [15:0]      timeout_ms;
		logic [ST_W-1:0]  sample_period_ms;
		logic [15:0]      beep_period_ms;
		logic [15:0]      result_hold_ms;
	} cfg_t;

endpackage

>>> src/scga_regs.sv
// APB register file holding the calibration settings.
`timescale 1ns / 1ps
module scga_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scga_pkg::ADDR_W-1:0]  paddr,
	input  logic [scga_pkg::DATA_W-1:0]  pwdata,
	output logic [scga_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output scga_pkg::cfg_t               cfg,
	output logic [scga_pkg::THR_W-1:0]   rh_sum
);
	import scga_pkg::*;

	cfg_t             cfg_q;
	logic [THR_W-1:0] rh_sum_q;
	logic [2:0]       idx;
	logic             wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign rh_sum = rh_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_threshold   <= RST_MOVE_THR;
			cfg_q.min_samples      <= RST_MIN_SAMPLES;
			cfg_q.ready_ms         <= RST_READY_MS;
			cfg_q.hold_ms          <= RST_HOLD_MS;
			cfg_q.timeout_ms       <= RST_TIMEOUT_MS;
			cfg_q.sample_period_ms <= RST_SAMPLE_PER;
			cfg_q.beep_period_ms   <= RST_BEEP_PER;
			cfg_q.result_hold_ms   <= RST_RESULT_HOLD;
		end else if (wr_en) begin
			unique case (idx)
				REG_MOVE_THR:    cfg_q.move_threshold   <= pwdata[THR_W-1:0];
				REG_MIN_SAMPLES: cfg_q.min_samples      <= pwdata[15:0];
				REG_READY_MS:    cfg_q.ready_ms         <= pwdata[15:0];
				REG_HOLD_MS:     cfg_q.hold_ms          <= pwdata[15:0];
				REG_TIMEOUT_MS:  cfg_q.timeout_ms       <= pwdata[15:0];
				REG_SAMPLE_PER:  cfg_q.sample_period_ms <= pwdata[ST_W-1:0];
				REG_BEEP_PER:    cfg_q.beep_period_ms   <= pwdata[15:0];
				REG_RESULT_HOLD: cfg_q.result_hold_ms   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// end of hold window, kept registered off the step path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rh_sum_q <= THR_W'(RST_READY_MS) + THR_W'(RST_HOLD_MS);
		end else begin
			rh_sum_q <= THR_W'(cfg_q.ready_ms) + THR_W'(cfg_q.hold_ms);
		end
	end

	always_comb begin
		unique case (idx)
			REG_MOVE_THR:    prdata = DATA_W'(cfg_q.move_threshold);
			REG_MIN_SAMPLES: prdata = DATA_W'(cfg_q.min_samples);
			REG_READY_MS:    prdata = DATA_W'(cfg_q.ready_ms);
			REG_HOLD_MS:     prdata = DATA_W'(cfg_q.hold_ms);
			REG_TIMEOUT_MS:  prdata = DATA_W'(cfg_q.timeout_ms);
			REG_SAMPLE_PER:  prdata = DATA_W'(cfg_q.sample_period_ms);
			REG_BEEP_PER:    prdata = DATA_W'(cfg_q.beep_period_ms);
			REG_RESULT_HOLD: prdata = DATA_W'(cfg_q.result_hold_ms);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> src/scga_div.sv
// Serial restoring divider: signed sum over sample count, one quotient bit per cycle, clamped.
`timescale 1ns / 1ps
module scga_div #(
	parameter int SAMPLE_WIDTH = scga_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = scga_pkg::SUM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [SUM_WIDTH-1:0]              dividend,
	input  logic [scga_pkg::CNT_W-1:0]        divisor,
	output logic                              done,
	output logic signed [SAMPLE_WIDTH-1:0]    quotient
);
	import scga_pkg::*;

	localparam int CW = $clog2(SUM_WIDTH + 1);
	localparam logic [SUM_WIDTH-1:0] POS_LIM =
		SUM_WIDTH'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic [SUM_WIDTH-1:0] NEG_LIM = POS_LIM + 1'b1;

	logic                 busy_q, done_q, neg_q, zero_q;
	logic [CW-1:0]        cnt_q;
	logic [SUM_WIDTH-1:0] quot_q;
	logic [CNT_W-1:0]     rem_q, dvs_q;
	logic [CNT_W:0]       trial, rem_sub;
	logic                 ge;
	logic [SUM_WIDTH-1:0] neg_mag;

	assign trial   = {rem_q, quot_q[SUM_WIDTH-1]};
	assign ge      = trial >= {1'b0, dvs_q};
	assign rem_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last quotient bit is shifted in
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[SUM_WIDTH-1];
			zero_q <= (divisor == '0);
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= dividend[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - dividend) : dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			quot_q <= {quot_q[SUM_WIDTH-2:0], ge};
		end
	end

	assign neg_mag = SUM_WIDTH'(0) - quot_q;
	assign done    = done_q;

	// truncating quotient, clamped into the sample range
	always_comb begin
		if (zero_q) begin
			quotient = '0;
		end else if (neg_q) begin
			if (quot_q > NEG_LIM) quotient = SAMPLE_WIDTH'(SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1));
			else                  quotient = neg_mag[SAMPLE_WIDTH-1:0];
		end else begin
			if (quot_q > POS_LIM) quotient = POS_LIM[SAMPLE_WIDTH-1:0];
			else                  quotient = quot_q[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

>>> src/stillness_gated_calibration_averager.sv
// Top level: tick stream in, one status transaction out per tick, APB settings port.
//
// Each input transaction is one millisecond tick: s_tdata carries the start and
// cancel requests and the current Y/Z accelerometer readings. For every tick the
// block returns exactly one status transaction on m_tdata: busy flag, phase,
// countdown beep, event code, visible result code, averages, sample count and
// elapsed ticks. The user must write settings over the APB port only while no
// tick is in work; the block itself does not enforce it.
//
// Timing: a tick is taken into the input registers and worked in the step state;
// its status is then registered. The tick that completes a calibration also runs
// both averages through the one shared serial divider, one quotient bit per cycle,
// before its status is raised. One tick is in work at a time.
//
// The output register holds a status until m_tready takes it; a new tick is
// taken in the same cycle the held status leaves, never while it is stuck.
// Reset puts the block idle with no pending start, cleared counters, no visible
// result and the settings at their defaults.
`timescale 1ns / 1ps
module stillness_gated_calibration_averager #(
	parameter int SAMPLE_WIDTH = scga_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = scga_pkg::SUM_WIDTH_DEF,
	parameter int TIMER_WIDTH  = scga_pkg::TIMER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_req[0], cancel_req[1], accel_y[17:2], accel_z[33:18], zero pad
	input  logic [scga_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// busy_res[0], phase[2:1], tick_beep[3], event_res[6:4], result_code[8:7],
	// avg_y[24:9], avg_z[40:25], samples_taken[56:41], elapsed_ticks[72:57], zero pad
	output logic [scga_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scga_pkg::ADDR_W-1:0]  paddr,
	input  logic [scga_pkg::DATA_W-1:0]  pwdata,
	output logic [scga_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import scga_pkg::*;

	localparam int TW    = TIMER_WIDTH;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int CMP_W = (TW > THR_W) ? TW + 1 : THR_W + 1;
	localparam int MV_W  = SW + 2;
	localparam int MVC_W = (MV_W > THR_W) ? MV_W : THR_W;
	localparam logic [TW-1:0]    TMAX    = '1;
	localparam logic [ST_W-1:0]  ST_MAX  = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC   = 3'd1;
	localparam logic [2:0] ST_DIV_Y  = 3'd2;
	localparam logic [2:0] ST_WAIT_Y = 3'd3;
	localparam logic [2:0] ST_DIV_Z  = 3'd4;
	localparam logic [2:0] ST_WAIT_Z = 3'd5;

	cfg_t             cfg;
	logic [THR_W-1:0] rh_sum;

	scga_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.rh_sum  (rh_sum)
	);

	logic [2:0]           state_q;
	logic                 in_start_q, in_cancel_q;
	logic [FIELD_W-1:0]   in_y_q, in_z_q;
	logic                 running_q, pending_q;
	logic [TW-1:0]        elapsed_q, beep_q, age_q;
	logic [ST_W-1:0]      samp_q;
	logic [SW-1:0]        prev_y_q, prev_z_q;
	logic [SUM_WIDTH-1:0] sum_y_q, sum_z_q;
	logic [CNT_W-1:0]     count_q;
	logic [1:0]           held_q;
	logic                 m_valid_q;

	logic                 o_busy_q, o_beep_q;
	logic [1:0]           o_phase_q, o_result_q;
	logic [2:0]           o_event_q;
	logic [FIELD_W-1:0]   o_avg_y_q, o_avg_z_q, o_samples_q, o_elapsed_q;

	// next-state values of one tick
	logic                 running_d, pending_d, beep_hit, fresh, complete, failed, pend;
	logic [TW-1:0]        elapsed_d, beep_d, age_d, ec_inc, bt_inc, age_inc;
	logic [ST_W-1:0]      samp_d, st_inc;
	logic [SW-1:0]        prev_y_d, prev_z_d;
	logic [SUM_WIDTH-1:0] sum_y_d, sum_z_d;
	logic [CNT_W-1:0]     count_d;
	logic [1:0]           held_d, phase_d;
	logic [2:0]           event_d;
	logic signed [SW-1:0] y_s, z_s;
	logic signed [SW:0]   dy, dz;
	logic [SW:0]          ady, adz;
	logic [MV_W-1:0]      mv;

	logic                    div_start, div_done;
	logic [SUM_WIDTH-1:0]    div_num;
	logic signed [SW-1:0]    div_q;

	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);

	assign y_s = in_y_q[SW-1:0];
	assign z_s = in_z_q[SW-1:0];
	assign dy  = (SW + 1)'(y_s) - (SW + 1)'($signed(prev_y_q));
	assign dz  = (SW + 1)'(z_s) - (SW + 1)'($signed(prev_z_q));
	assign ady = dy[SW] ? ((SW + 1)'(0) - dy) : dy;
	assign adz = dz[SW] ? ((SW + 1)'(0) - dz) : dz;
	assign mv  = MV_W'(ady) + MV_W'(adz);

	assign ec_inc  = (elapsed_q != TMAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign bt_inc  = (beep_q != TMAX) ? beep_q + 1'b1 : beep_q;
	assign age_inc = (age_q != TMAX) ? age_q + 1'b1 : age_q;
	assign st_inc  = (samp_q != ST_MAX) ? samp_q + 1'b1 : samp_q;

	always_comb begin
		pend      = pending_q | in_start_q;
		running_d = running_q;
		pending_d = pend;
		elapsed_d = elapsed_q;
		beep_d    = beep_q;
		samp_d    = samp_q;
		prev_y_d  = prev_y_q;
		prev_z_d  = prev_z_q;
		sum_y_d   = sum_y_q;
		sum_z_d   = sum_z_q;
		count_d   = count_q;
		held_d    = held_q;
		age_d     = age_q;
		event_d   = EV_NONE;
		beep_hit  = 1'b0;
		fresh     = 1'b0;
		complete  = 1'b0;
		failed    = 1'b0;

		if (in_cancel_q) begin
			if (running_q) begin
				running_d = 1'b0;
				event_d   = EV_CANCEL;
			end
		end else if (pend && !running_q) begin
			pending_d = 1'b0;
			running_d = 1'b1;
			elapsed_d = '0;
			beep_d    = '0;
			samp_d    = '0;
			prev_y_d  = y_s;
			prev_z_d  = z_s;
			sum_y_d   = '0;
			sum_z_d   = '0;
			count_d   = '0;
			held_d    = RES_NONE;
			age_d     = '0;
			event_d   = EV_START;
		end else if (running_q) begin
			elapsed_d = ec_inc;
			samp_d    = st_inc;
			if (CMP_W'(ec_inc) > CMP_W'(cfg.timeout_ms)) begin
				running_d = 1'b0;
				held_d    = RES_FAILED;
				age_d     = '0;
				fresh     = 1'b1;
				event_d   = EV_TIMEOUT;
			end else if (CMP_W'(ec_inc) < CMP_W'(cfg.ready_ms)) begin
				if (CMP_W'(bt_inc) >= CMP_W'(cfg.beep_period_ms)) begin
					beep_hit = 1'b1;
					beep_d   = '0;
				end else begin
					beep_d = bt_inc;
				end
				prev_y_d = y_s;
				prev_z_d = z_s;
				sum_y_d  = '0;
				sum_z_d  = '0;
				count_d  = '0;
			end else begin
				if (st_inc >= cfg.sample_period_ms) begin
					samp_d   = '0;
					prev_y_d = y_s;
					prev_z_d = z_s;
					if (MVC_W'(mv) > MVC_W'(cfg.move_threshold)) begin
						running_d = 1'b0;
						held_d    = RES_FAILED;
						age_d     = '0;
						fresh     = 1'b1;
						event_d   = EV_MOVED;
						failed    = 1'b1;
					end else if (count_q != CNT_MAX) begin
						sum_y_d = sum_y_q + SUM_WIDTH'(y_s);
						sum_z_d = sum_z_q + SUM_WIDTH'(z_s);
						count_d = count_q + 1'b1;
					end
				end
				if (!failed && CMP_W'(ec_inc) > CMP_W'(rh_sum) &&
				    count_d >= cfg.min_samples) begin
					running_d = 1'b0;
					held_d    = RES_COMPLETE;
					age_d     = '0;
					fresh     = 1'b1;
					complete  = 1'b1;
					event_d   = EV_COMPLETE;
				end
			end
		end

		// result window ages after the step
		if (held_d != RES_NONE && !fresh && !running_d) begin
			if (CMP_W'(age_inc) > CMP_W'(cfg.result_hold_ms)) begin
				held_d = RES_NONE;
				age_d  = '0;
			end else begin
				age_d = age_inc;
			end
		end

		if (!running_d) phase_d = PH_IDLE;
		else if (CMP_W'(elapsed_d) < CMP_W'(cfg.ready_ms)) phase_d = PH_READY;
		else phase_d = PH_HOLD;
	end

	assign div_start = (state_q == ST_DIV_Y) || (state_q == ST_DIV_Z);
	assign div_num   = (state_q == ST_DIV_Y) ? sum_y_q : sum_z_q;

	scga_div #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_WIDTH    (SUM_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			pending_q <= 1'b0;
			elapsed_q <= '0;
			beep_q    <= '0;
			samp_q    <= '0;
			prev_y_q  <= '0;
			prev_z_q  <= '0;
			sum_y_q   <= '0;
			sum_z_q   <= '0;
			count_q   <= '0;
			held_q    <= RES_NONE;
			age_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) state_q <= ST_CALC;
				end
				ST_CALC: begin
					running_q <= running_d;
					pending_q <= pending_d;
					elapsed_q <= elapsed_d;
					beep_q    <= beep_d;
					samp_q    <= samp_d;
					prev_y_q  <= prev_y_d;
					prev_z_q  <= prev_z_d;
					sum_y_q   <= sum_y_d;
					sum_z_q   <= sum_z_d;
					count_q   <= count_d;
					held_q    <= held_d;
					age_q     <= age_d;
					if (complete) begin
						state_q <= ST_DIV_Y;
					end else begin
						state_q   <= ST_IDLE;
						m_valid_q <= 1'b1;
					end
				end
				ST_DIV_Y:  state_q <= ST_WAIT_Y;
				ST_WAIT_Y: begin
					if (div_done) state_q <= ST_DIV_Z;
				end
				ST_DIV_Z:  state_q <= ST_WAIT_Z;
				ST_WAIT_Z: begin
					if (div_done) begin
						state_q   <= ST_IDLE;
						m_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tick payload and status payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_start_q  <= s_tdata[0];
			in_cancel_q <= s_tdata[1];
			in_y_q      <= s_tdata[17:2];
			in_z_q      <= s_tdata[33:18];
		end
		if (state_q == ST_CALC) begin
			o_busy_q    <= running_d;
			o_phase_q   <= phase_d;
			o_beep_q    <= beep_hit;
			o_event_q   <= event_d;
			o_result_q  <= running_d ? RES_NONE : held_d;
			o_avg_y_q   <= '0;
			o_avg_z_q   <= '0;
			o_samples_q <= count_d;
			o_elapsed_q <= running_d ? FIELD_W'(elapsed_d) : '0;
		end
		if (state_q == ST_WAIT_Y && div_done) o_avg_y_q <= FIELD_W'(div_q);
		if (state_q == ST_WAIT_Z && div_done) o_avg_z_q <= FIELD_W'(div_q);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, o_elapsed_q, o_samples_q, o_avg_z_q, o_avg_y_q,
	                   o_result_q, o_event_q, o_beep_q, o_phase_q, o_busy_q};

	// divider finishes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT_Y || state_q == ST_WAIT_Z))
		else $error("divider done outside a wait state");

	// a status appears only after the step or after the last division
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_CALC || $past(state_q) == ST_WAIT_Z))
		else $error("status raised from an unexpected state");

	// a running calibration never carries a visible result
	a_run_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (held_q == RES_NONE))
		else $error("held result while running");

	// a busy status never reports a result code
	a_busy_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && o_busy_q |-> (o_result_q == RES_NONE))
		else $error("busy status with a result code");

endmodule
